// ----- design/tree_bitmap_visibility_closure_macros.svh -----
// ----------------------------------------------------------------------------
// tree bitmap visibility closure assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TREE_BITMAP_VISIBILITY_CLOSURE_MACROS_SVH
`define TREE_BITMAP_VISIBILITY_CLOSURE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define TBVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define TBVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TBVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TBVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tbvc_pkg.sv -----
// ----------------------------------------------------------------------------
// tbvc_pkg
// shared widths, op codes and item types of the tree bitmap visibility block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbvc_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_MODELS  = 4;
    localparam int NODE_W      = 10;
    localparam int MODEL_W     = 2;
    localparam int OP_W        = 2;
    localparam int COUNT_W     = 11;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;
    localparam int ROW_W       = NODE_W - BIT_W;
    localparam int ADDR_W      = MODEL_W + ROW_W;
    localparam int ROWS        = MAX_MODELS * (MAX_NODES / WORD_W);
    localparam int ROWS_PER_M  = MAX_NODES / WORD_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [OP_W-1:0]    OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0]    OP_MARK     = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd1024;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [MODEL_W-1:0] model;
        logic [NODE_W-1:0]  node;
    } t_in_item;

    typedef struct packed {
        logic visible;
        logic status;
    } t_out_item;

    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               clr_en;
        logic [MODEL_W-1:0] clr_model;
    } t_ram_req;

    typedef logic [MAX_MODELS-1:0][COUNT_W-1:0] t_counts;

endpackage

`default_nettype wire

// ----- design/tbvc_store.sv -----
// ----------------------------------------------------------------------------
// tbvc_store
// word-wide bitmap memory with per-row valid bits and registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbvc_store (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tbvc_pkg::t_ram_req             i_req,
    output logic [tbvc_pkg::WORD_W-1:0]         o_rdata
);

    logic [tbvc_pkg::WORD_W-1:0] r_mem [tbvc_pkg::ROWS];
    logic [tbvc_pkg::ROWS-1:0]   r_row_valid;
    logic [tbvc_pkg::WORD_W-1:0] r_rdata;
    logic                        r_rd_ok;

    // memory array, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    // row valid bits: a row that is not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (i_req.clr_en) begin
                r_row_valid[i_req.clr_model*tbvc_pkg::ROWS_PER_M +: tbvc_pkg::ROWS_PER_M]
                    <= '0;
            end
            if (i_req.wr_en) begin
                r_row_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_row_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

`default_nettype wire

// ----- design/tbvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbvc_ctrl
// operation sequencer: clear, query, and for a mark an ancestor walk and level-by-level descendant fill
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tree_bitmap_visibility_closure_macros.svh"

module tbvc_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tbvc_pkg::t_counts              i_counts,
    input  wire logic                           i_in_valid,
    input  wire tbvc_pkg::t_in_item             i_in_item,
    output logic                                o_busy,
    input  wire logic                           i_res_ready,
    output logic                                o_res_valid,
    output tbvc_pkg::t_out_item                 o_res,
    output tbvc_pkg::t_ram_req                  o_ram_req,
    input  wire logic [tbvc_pkg::WORD_W-1:0]    i_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_ARD, S_AWR, S_DCHK, S_DRD, S_DWR, S_QRD, S_QDAT, S_FIN
    } t_state;

    t_state                           r_state, n_state;
    logic [tbvc_pkg::MODEL_W-1:0]     r_model, n_model;
    logic [tbvc_pkg::NODE_W-1:0]      r_node, n_node;
    logic [tbvc_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [tbvc_pkg::NODE_W-1:0]      r_a, n_a;
    logic [tbvc_pkg::COUNT_W-1:0]     r_lo, n_lo;
    logic [tbvc_pkg::COUNT_W-1:0]     r_hi, n_hi;
    logic [tbvc_pkg::NODE_W-1:0]      r_top, n_top;
    logic [tbvc_pkg::ROW_W-1:0]       r_w, n_w;
    logic                             r_vis, n_vis;
    logic                             r_status, n_status;

    logic [tbvc_pkg::COUNT_W-1:0]     eff_in;
    logic [tbvc_pkg::COUNT_W-1:0]     cnt_m1;
    logic [tbvc_pkg::COUNT_W:0]       hi_x2;
    logic [tbvc_pkg::BIT_W-1:0]       lo_b, hi_b;
    logic [tbvc_pkg::WORD_W-1:0]      fill_mask;
    tbvc_pkg::t_ram_req               req;
    logic                             res_valid;

    // effective count of the addressed model, capped at tree capacity
    always_comb begin
        eff_in = i_counts[i_in_item.model];
        if (eff_in > tbvc_pkg::COUNT_MAX) begin
            eff_in = tbvc_pkg::COUNT_MAX;
        end
    end

    assign cnt_m1 = r_count - 11'd1;
    assign hi_x2  = {r_hi, 1'b0} + 12'd2;

    // bit range of the current level inside word r_w
    assign lo_b = (r_w == r_lo[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W]) ?
                  r_lo[tbvc_pkg::BIT_W-1:0] : '0;
    assign hi_b = (r_w == r_top[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W]) ?
                  r_top[tbvc_pkg::BIT_W-1:0] : '1;
    assign fill_mask = ({tbvc_pkg::WORD_W{1'b1}} << lo_b) &
                       ({tbvc_pkg::WORD_W{1'b1}} >> (5'd31 - hi_b));

    always_comb begin
        n_state  = r_state;
        n_model  = r_model;
        n_node   = r_node;
        n_count  = r_count;
        n_a      = r_a;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_top    = r_top;
        n_w      = r_w;
        n_vis    = r_vis;
        n_status = r_status;
        req      = '0;
        res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_model = i_in_item.model;
                    n_node  = i_in_item.node;
                    n_count = eff_in;
                    n_vis   = 1'b0;
                    n_status = 1'b0;
                    if (i_in_item.op == tbvc_pkg::OP_CLEAR) begin
                        req.clr_en    = 1'b1;
                        req.clr_model = i_in_item.model;
                        n_state = S_FIN;
                    end else if ({1'b0, i_in_item.node} >= eff_in) begin
                        n_status = 1'b1;
                        n_state  = S_FIN;
                    end else if (i_in_item.op == tbvc_pkg::OP_MARK) begin
                        n_vis   = 1'b1;
                        n_a     = i_in_item.node;
                        n_state = S_ARD;
                    end else begin
                        n_state = S_QRD;
                    end
                end
            end
            S_ARD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = {r_model, r_a[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W]};
                n_state = S_AWR;
            end
            S_AWR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = {r_model, r_a[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W]};
                req.wr_data = i_rdata |
                              ({{(tbvc_pkg::WORD_W-1){1'b0}}, 1'b1} << r_a[tbvc_pkg::BIT_W-1:0]);
                if (r_a == '0) begin
                    n_lo    = {1'b0, r_node};
                    n_hi    = {1'b0, r_node};
                    n_state = S_DCHK;
                end else begin
                    n_a     = (r_a - 10'd1) >> 1;
                    n_state = S_ARD;
                end
            end
            S_DCHK: begin
                if (r_lo >= r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_top   = (r_hi >= cnt_m1) ? cnt_m1[tbvc_pkg::NODE_W-1:0] :
                                                 r_hi[tbvc_pkg::NODE_W-1:0];
                    n_w     = r_lo[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W];
                    n_state = S_DRD;
                end
            end
            S_DRD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = {r_model, r_w};
                n_state = S_DWR;
            end
            S_DWR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = {r_model, r_w};
                req.wr_data = i_rdata | fill_mask;
                if (r_w == r_top[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W]) begin
                    n_lo = {r_lo[tbvc_pkg::NODE_W-1:0], 1'b1};
                    if (r_hi[tbvc_pkg::COUNT_W-1]) begin
                        n_hi = r_hi;
                    end else if (hi_x2[tbvc_pkg::COUNT_W]) begin
                        n_hi = '1;
                    end else begin
                        n_hi = hi_x2[tbvc_pkg::COUNT_W-1:0];
                    end
                    n_state = S_DCHK;
                end else begin
                    n_w     = r_w + 5'd1;
                    n_state = S_DRD;
                end
            end
            S_QRD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = {r_model, r_node[tbvc_pkg::NODE_W-1:tbvc_pkg::BIT_W]};
                n_state = S_QDAT;
            end
            S_QDAT: begin
                n_vis   = i_rdata[r_node[tbvc_pkg::BIT_W-1:0]];
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_res_ready) begin
                    res_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_model  <= n_model;
        r_node   <= n_node;
        r_count  <= n_count;
        r_a      <= n_a;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_top    <= n_top;
        r_w      <= n_w;
        r_vis    <= n_vis;
        r_status <= n_status;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_ram_req     = req;
    assign o_res_valid   = res_valid;
    assign o_res.visible = r_vis;
    assign o_res.status  = r_status;

    `TBVC_ASSERT_NOW(a_no_rd_wr_overlap, i_clk, i_rst_n, req.rd_en, !req.wr_en && !req.clr_en)
    `TBVC_ASSERT_NEXT(a_rd_then_use, i_clk, i_rst_n, req.rd_en, req.wr_en || r_state == S_QDAT)
    `TBVC_ASSERT_NOW(a_wr_sets_bits, i_clk, i_rst_n, req.wr_en, req.wr_data != '0)

endmodule

`default_nettype wire

// ----- design/tree_bitmap_visibility_closure.sv -----
// sequence: a clear or out-of-range item goes straight to the finish state; a query
// reads the addressed word and then takes its bit; a mark reads and writes the word of
// each ancestor up to the root, then fills each descendant level word by word
// throughput: one item at a time; each bitmap word is read and then written back
// reset: synchronous active low; node counts return to 1024, all row valid bits clear
// at once so every bitmap reads as zero, no clearing pass
// ----------------------------------------------------------------------------
// tree_bitmap_visibility_closure
// per-model heap tree visibility bitmap with mark closure, clear and query
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tree_bitmap_visibility_closure (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [tbvc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tbvc_pkg::COUNT_W-1:0]        i_cfg_data,
    // input item channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire tbvc_pkg::t_in_item                  i_in_item,
    // result item channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output tbvc_pkg::t_out_item                      o_out_item
);

    tbvc_pkg::t_counts    r_counts;
    logic                 r_out_valid;
    tbvc_pkg::t_out_item  r_out_item;

    logic                 busy;
    logic                 res_ready;
    logic                 res_valid;
    tbvc_pkg::t_out_item  res;
    tbvc_pkg::t_ram_req   ram_req;
    logic [tbvc_pkg::WORD_W-1:0] rdata;

    // node count registers, one per model
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tbvc_pkg::MAX_MODELS; i++) begin
                r_counts[i] <= tbvc_pkg::COUNT_RESET;
            end
        end else if (i_cfg_we) begin
            r_counts[i_cfg_index] <= i_cfg_data;
        end
    end

    // output register decouples the sequencer from a stalled consumer
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out_item <= res;
        end
    end

    // sequencer: one item in flight, a mark walks ancestors then descendant levels
    tbvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_counts    (r_counts),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_busy      (busy),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_req   (ram_req),
        .i_rdata     (rdata)
    );

    // bitmap memory: 32-bit rows, 32 rows per model
    tbvc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
